>>> rtl/bagm_pkg.sv
package bagm_pkg;

    localparam int DEF_MAX_WIDTH     = 1024;
    localparam int DEF_MAX_CELL_SIZE = 32;
    localparam int HEIGHT_LIMIT      = 1024;

    localparam int SUM_W  = 18;
    localparam int CFG_IW = 3;

    typedef enum logic [CFG_IW-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_CELL_WIDTH   = 3'd2,
        REG_CELL_HEIGHT  = 3'd3,
        REG_LEVEL_MAX    = 3'd4
    } cfg_reg_t;

    // one-hot sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

endpackage

>>> rtl/block_average_ascii_glyph_mapper.sv
// A closing pixel's result is made by a memory read, a sum update, a restoring
// divide and a level scale; other pixels give no result and only write their sum.
// A pixel is taken only once the last one is through the read-modify-write of
// the sum memory, and after a cell's last pixel also once its result is loaded
// into the output register; a result still waiting there holds the next closing
// pixel's final load and config writes, but not the acceptance of other pixels.
// Reset (aresetn low, synchronous): registers return to 640x480, 6x12 cells,
// level_max 28, position at top-left. The sum memory is not cleared.
module block_average_ascii_glyph_mapper
    import bagm_pkg::*;
#(
    parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
    parameter int MAX_CELL_SIZE = DEF_MAX_CELL_SIZE
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,       // [7:0] pixel
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,       // [7:0] glyph_level, [15:8] cell_mean
    output logic              m_tlast,       // frame_end
    output logic              m_tuser,       // line_end
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [10:0]       cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_CELL_SIZE + 1);
    localparam int PW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(HEIGHT_LIMIT + 1);
    localparam int NW = 2 * CW;

    // configuration registers, stored as written, cell sizes cut to 6 bits and level_max to 8 bits
    logic [10:0] fw_reg, fh_reg;
    logic [5:0]  cw_reg, ch_reg;
    logic [7:0]  lm_reg;

    // clamped sizes
    logic [PW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [CW-1:0] cw_eff, ch_eff;

    always_comb begin
        if (fw_reg == 11'd0) w_eff = PW'(1);
        else if (32'(fw_reg) > MAX_WIDTH) w_eff = PW'(MAX_WIDTH);
        else w_eff = PW'(fw_reg);
        if (fh_reg == 11'd0) h_eff = HW'(1);
        else if (32'(fh_reg) > HEIGHT_LIMIT) h_eff = HW'(HEIGHT_LIMIT);
        else h_eff = HW'(fh_reg);
        if (cw_reg == 6'd0) cw_eff = CW'(1);
        else if (32'(cw_reg) > MAX_CELL_SIZE) cw_eff = CW'(MAX_CELL_SIZE);
        else cw_eff = CW'(cw_reg);
        if (ch_reg == 6'd0) ch_eff = CW'(1);
        else if (32'(ch_reg) > MAX_CELL_SIZE) ch_eff = CW'(MAX_CELL_SIZE);
        else ch_eff = CW'(ch_reg);
    end

    // frame position
    logic [PW-1:0] pcol_reg;
    logic [HW-1:0] prow_reg;
    logic [CW-1:0] cic_reg, rib_reg;
    logic [AW-1:0] ccol_reg;

    state_t state_reg;

    // item latched at acceptance
    logic [7:0]    pix_reg;
    logic          first_reg, close_reg, rend_reg, fend_reg;
    logic [NW-1:0] cnt_reg;
    logic [AW-1:0] addr_reg;

    // sum memory
    logic [SUM_W-1:0] mem [MAX_WIDTH];
    logic [SUM_W-1:0] rd_reg;
    logic             mem_we;
    logic [SUM_W-1:0] sum_new;

    // divider / scaler
    logic [SUM_W-1:0] quo_reg;
    logic [SUM_W-1:0] rem_reg;
    logic [4:0]       dstep_reg;
    logic             scale_reg;
    logic [15:0]      prod_reg;

    logic [15:0] mdata_reg;
    logic        mvalid_reg, mlast_reg, muser_reg;

    logic s_fire, cfg_fire;
    logic row_end, col_end, last_col, last_row;

    // a waiting result holds the final load and config writes, not the next pixel
    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE) && !mvalid_reg;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign row_end  = (32'(pcol_reg) + 1 >= 32'(w_eff));
    assign col_end  = (32'(prow_reg) + 1 >= 32'(h_eff));
    assign last_col = row_end || (32'(cic_reg) + 1 >= 32'(cw_eff));
    assign last_row = col_end || (32'(rib_reg) + 1 >= 32'(ch_eff));

    assign sum_new = first_reg ? SUM_W'(pix_reg) : rd_reg + SUM_W'(pix_reg);
    assign mem_we  = (state_reg == ST_READ);

    // memory: read at acceptance, write back in the following cycle
    always_ff @(posedge aclk) begin
        if (s_fire) rd_reg <= mem[ccol_reg];
        if (mem_we) mem[addr_reg] <= sum_new;
    end

    // restoring divide step: shift next quotient bit of the dividend in
    logic [SUM_W:0] trial;
    assign trial = {rem_reg, quo_reg[SUM_W-1]} - (SUM_W+1)'(cnt_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg <= 11'd640; fh_reg <= 11'd480;
            cw_reg <= 6'd6;    ch_reg <= 6'd12;
            lm_reg <= 8'd28;
            pcol_reg <= '0; prow_reg <= '0; cic_reg <= '0; rib_reg <= '0;
            ccol_reg <= '0;
            state_reg <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            if (m_tready && (state_reg != ST_OUT)) mvalid_reg <= 1'b0;
            if (cfg_fire) begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  fw_reg <= cfg_data;
                    REG_FRAME_HEIGHT: fh_reg <= cfg_data;
                    REG_CELL_WIDTH:   cw_reg <= cfg_data[5:0];
                    REG_CELL_HEIGHT:  ch_reg <= cfg_data[5:0];
                    REG_LEVEL_MAX:    lm_reg <= cfg_data[7:0];
                    default: ;
                endcase
                if (cfg_index <= REG_LEVEL_MAX) begin
                    pcol_reg <= '0; prow_reg <= '0; cic_reg <= '0;
                    rib_reg <= '0; ccol_reg <= '0;
                end
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        pix_reg   <= s_tdata;
                        first_reg <= (cic_reg == '0) && (rib_reg == '0);
                        close_reg <= last_col && last_row;
                        rend_reg  <= row_end;
                        fend_reg  <= row_end && col_end;
                        cnt_reg   <= NW'((32'(cic_reg) + 1) * (32'(rib_reg) + 1));
                        addr_reg  <= ccol_reg;
                        state_reg <= ST_READ;
                        if (row_end) begin
                            pcol_reg <= '0; cic_reg <= '0; ccol_reg <= '0;
                            if (col_end) begin
                                prow_reg <= '0; rib_reg <= '0;
                            end else begin
                                prow_reg <= prow_reg + HW'(1);
                                rib_reg  <= last_row ? '0 : rib_reg + CW'(1);
                            end
                        end else begin
                            pcol_reg <= pcol_reg + PW'(1);
                            if (last_col) begin
                                cic_reg  <= '0;
                                ccol_reg <= ccol_reg + AW'(1);
                            end else begin
                                cic_reg <= cic_reg + CW'(1);
                            end
                        end
                    end
                end
                ST_READ: begin
                    quo_reg   <= sum_new;
                    rem_reg   <= '0;
                    dstep_reg <= '0;
                    scale_reg <= 1'b0;
                    state_reg <= close_reg ? ST_DIV : ST_IDLE;
                end
                ST_DIV: begin
                    if (32'(dstep_reg) < SUM_W) begin
                        if (!trial[SUM_W]) begin
                            rem_reg <= trial[SUM_W-1:0];
                            quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
                        end else begin
                            rem_reg <= {rem_reg[SUM_W-2:0], quo_reg[SUM_W-1]};
                            quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
                        end
                        dstep_reg <= dstep_reg + 5'd1;
                    end else if (!scale_reg) begin
                        // saturate mean, then multiply by level_max
                        if (quo_reg > SUM_W'(255)) quo_reg <= SUM_W'(255);
                        prod_reg  <= (quo_reg > SUM_W'(255) ? 8'd255 : quo_reg[7:0])
                                     * lm_reg;
                        scale_reg <= 1'b1;
                    end else begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // load once the output register is free or being taken
                    if (!mvalid_reg || m_tready) begin
                        // divide by 255: (p + 1 + (p >> 8)) >> 8 exact for p < 65535
                        mdata_reg  <= {quo_reg[7:0],
                                       8'((17'(prod_reg) + 17'd1 + 17'(prod_reg[15:8])) >> 8)};
                        mlast_reg  <= fend_reg;
                        muser_reg  <= rend_reg;
                        mvalid_reg <= 1'b1;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;
    assign m_tuser  = muser_reg;

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bagm_pkg::*;

    localparam int MAX_W       = DEF_MAX_WIDTH;
    localparam int MAX_CELL    = DEF_MAX_CELL_SIZE;
    localparam int ITEM_TARGET = 1450;
    localparam int SETTLE      = 40;   // longer than a closing pixel takes to reach the output
    localparam logic [CFG_IW-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [7:0] glyph;
        logic [7:0] mean;
        logic       line_end;
        logic       frame_end;
    } glyph_cell_t;

    // Mirrors the block's registers and counters and predicts each closing
    // pixel's cell result; checks results in order.
    class glyph_scoreboard;
        int unsigned frame_w, frame_h, cell_w, cell_h, level_max;
        logic [17:0] band_sums [MAX_W];
        int unsigned px_col, px_row, col_in_cell, row_in_band, cell_col;
        glyph_cell_t pending_cells[$];
        int errors;

        function new();
            frame_w = 640; frame_h = 480; cell_w = 6; cell_h = 12; level_max = 28;
            errors = 0;
            home();
        endfunction

        function void home();
            px_col = 0; px_row = 0; col_in_cell = 0; row_in_band = 0; cell_col = 0;
        endfunction

        function int unsigned fit(int unsigned v, int unsigned hi);
            if (v == 0) return 1;
            return (v > hi) ? hi : v;
        endfunction

        function void write_reg(logic [CFG_IW-1:0] idx, logic [10:0] data);
            case (idx)
                REG_FRAME_WIDTH:  frame_w = 32'(data);
                REG_FRAME_HEIGHT: frame_h = 32'(data);
                REG_CELL_WIDTH:   cell_w = 32'(data[5:0]);
                REG_CELL_HEIGHT:  cell_h = 32'(data[5:0]);
                REG_LEVEL_MAX:    level_max = 32'(data[7:0]);
                default:          return;  // unmapped index: no effect at all
            endcase
            home();
        endfunction

        function void note_pixel(logic [7:0] pix);
            int unsigned w, h, cw, ch, idx, mean;
            logic [17:0] sum;
            bit row_end, col_end, last_col, last_row;
            glyph_cell_t c;
            w  = fit(frame_w, MAX_W);
            h  = fit(frame_h, HEIGHT_LIMIT);
            cw = fit(cell_w, MAX_CELL);
            ch = fit(cell_h, MAX_CELL);
            idx = (cell_col >= MAX_W) ? MAX_W - 1 : cell_col;
            // first pixel of a cell overwrites the stale entry
            if (col_in_cell == 0 && row_in_band == 0) sum = 18'(pix);
            else sum = 18'(band_sums[idx] + 18'(pix));
            band_sums[idx] = sum;
            row_end  = (px_col + 1 >= w);
            col_end  = (px_row + 1 >= h);
            last_col = row_end || (col_in_cell + 1 >= cw);
            last_row = col_end || (row_in_band + 1 >= ch);
            if (last_col && last_row) begin
                mean = sum / ((col_in_cell + 1) * (row_in_band + 1));
                if (mean > 255) mean = 255;
                c.mean      = 8'(mean);
                c.glyph     = 8'((mean * level_max) / 255);
                c.line_end  = row_end;
                c.frame_end = row_end && col_end;
                pending_cells.push_back(c);
            end
            if (row_end) begin
                px_col = 0; col_in_cell = 0; cell_col = 0;
                if (col_end) begin
                    px_row = 0; row_in_band = 0;
                end else begin
                    px_row++;
                    row_in_band = last_row ? 0 : row_in_band + 1;
                end
            end else begin
                px_col++;
                if (last_col) begin
                    col_in_cell = 0; cell_col++;
                end else begin
                    col_in_cell++;
                end
            end
        endfunction

        function void check_cell(glyph_cell_t got);
            glyph_cell_t want;
            if (pending_cells.size() == 0) begin
                $display("%0t: unexpected cell result %h", $time, got);
                errors++;
                return;
            end
            want = pending_cells.pop_front();
            if (got.glyph !== want.glyph) begin
                $display("%0t: glyph_level expected %0d actual %0d", $time, want.glyph, got.glyph);
                errors++;
            end
            if (got.mean !== want.mean) begin
                $display("%0t: cell_mean expected %0d actual %0d", $time, want.mean, got.mean);
                errors++;
            end
            if (got.line_end !== want.line_end) begin
                $display("%0t: line_end expected %0b actual %0b", $time,
                         want.line_end, got.line_end);
                errors++;
            end
            if (got.frame_end !== want.frame_end) begin
                $display("%0t: frame_end expected %0b actual %0b", $time,
                         want.frame_end, got.frame_end);
                errors++;
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = '0;     // [7:0] pixel
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;          // [7:0] glyph_level, [15:8] cell_mean
    logic              m_tlast;          // frame_end
    logic              m_tuser;          // line_end
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [10:0]       cfg_data = '0;

    glyph_scoreboard sb = new();
    int pixels_sent = 0;
    int send_idle_pct = 36;
    int take_idle_pct = 49;

    block_average_ascii_glyph_mapper i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // Result side: check each taken item, stall at random per the idle profile.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_cell({m_tdata[7:0], m_tdata[15:8], m_tuser, m_tlast});
        m_tready <= aresetn && ($urandom_range(99) >= take_idle_pct);
    end

    // Idle profile follows progress: receiver-heavy, then sender-heavy, then none.
    always @(posedge aclk) begin
        if (pixels_sent < ITEM_TARGET / 3) begin
            send_idle_pct <= 36; take_idle_pct <= 49;
        end else if (pixels_sent < 2 * ITEM_TARGET / 3) begin
            send_idle_pct <= 49; take_idle_pct <= 36;
        end else begin
            send_idle_pct <= 0; take_idle_pct <= 0;
        end
    end

    // Config writes only with the block drained and settled.
    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [10:0] data);
        while (sb.pending_cells.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(logic [10:0] w, logic [10:0] h, logic [10:0] cw,
                             logic [10:0] ch, logic [10:0] lvl);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_CELL_WIDTH, cw);
        write_reg(REG_CELL_HEIGHT, ch);
        write_reg(REG_LEVEL_MAX, lvl);
    endtask

    // One pixel item; valid stays high across back-to-back items.
    task automatic send_pixel(logic [7:0] pix);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(pix);
        pixels_sent++;
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial begin
        int w, h, n;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset geometry (640x480, 6x12 cells): a partial row, no cell closes
        for (int i = 0; i < 8; i++) send_pixel(i[0] ? 8'd255 : 8'd0);
        end_burst();

        // 3x2 frame of 2x2 cells at full scale; edge cell is cut narrow
        set_frame(11'd3, 11'd2, 11'd2, 11'd2, 11'd255);
        send_pixel(8'd255); send_pixel(8'd255); send_pixel(8'd0);
        send_pixel(8'd255); send_pixel(8'd254); send_pixel(8'd1);
        end_burst();

        // zero sizes act as one; level 0 gives glyph 0
        set_frame(11'd0, 11'd0, 11'd0, 11'd0, 11'd0);
        send_pixel(8'd255); send_pixel(8'd128);
        end_burst();

        // oversized registers saturate; level value masked to 8 bits
        set_frame(11'd1, 11'h7FF, 11'h3F, 11'h3F, 11'h7FF);
        for (int i = 0; i < 34; i++) send_pixel(8'd255);
        end_burst();

        // unmapped index is ignored and keeps the frame position
        write_reg(REG_UNUSED, 11'h555);
        for (int i = 0; i < 30; i++) send_pixel(rand_pixel());
        end_burst();

        // widest row: width saturates at the column limit, 32-wide cells
        set_frame(11'h7FF, 11'd1, 11'd32, 11'd1, 11'd28);
        for (int i = 0; i < MAX_W; i++) send_pixel(rand_pixel());
        end_burst();

        // random geometries: mostly whole frames, some cut off by the next write
        while (pixels_sent < ITEM_TARGET) begin
            w = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
            h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
            set_frame(11'(w), 11'(h),
                      ($urandom_range(7) == 0) ? 11'h7FF : 11'($urandom_range(0, 8)),
                      ($urandom_range(7) == 0) ? 11'h7C0 | 11'($urandom_range(63))
                                               : 11'($urandom_range(0, 5)),
                      11'($urandom_range(0, 2047)));
            n = (w == 0 ? 1 : w) * (h == 0 ? 1 : h) * $urandom_range(1, 3);
            if ($urandom_range(4) == 0) n = n + $urandom_range(1, 5);
            for (int i = 0; i < n; i++) send_pixel(rand_pixel());
            end_burst();
        end

        while (sb.pending_cells.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (sb.errors == 0)
            $display("block_average_ascii_glyph_mapper regression: pass");
        else
            $display("block_average_ascii_glyph_mapper regression: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("block_average_ascii_glyph_mapper regression: fail");
        $finish;
    end

endmodule

>>> files.f
rtl/bagm_pkg.sv
rtl/block_average_ascii_glyph_mapper.sv
test/testbench.sv
